### rtl/quaternion_trs_matrix_core_assert.svh
// Assertion helpers for the transform core. Both sample on clk and are
// disabled while rst_n is low; the enclosing module supplies both names.
`ifndef QUATERNION_TRS_MATRIX_CORE_ASSERT_SVH
`define QUATERNION_TRS_MATRIX_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QTRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QTRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qtrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qtrs_pkg;

    localparam int QUAT_W  = 16;
    localparam int SCALE_W = 16;
    localparam int TRANS_W = 32;
    localparam int OUT_W   = 32;
    localparam int PROD_W  = 2 * QUAT_W + 1;     // doubled quaternion product
    localparam int ENTRY_W = PROD_W + 1;         // rotation entry, units of 2^-28
    localparam int WIDE_W  = ENTRY_W + SCALE_W;  // scaled entry, units of 2^-36
    localparam int SHIFT   = 20;
    localparam int NUM_ENT = 9;

    // Rotation entry positions, row-major
    localparam int E00 = 0;
    localparam int E01 = 1;
    localparam int E02 = 2;
    localparam int E10 = 3;
    localparam int E11 = 4;
    localparam int E12 = 5;
    localparam int E20 = 6;
    localparam int E21 = 7;
    localparam int E22 = 8;

    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [SCALE_W-1:0] scale_t;
    typedef logic signed [TRANS_W-1:0] trans_t;
    typedef logic signed [OUT_W-1:0]   res_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    localparam entry_t ONE_Q28  = entry_t'(64'sd268435456);
    localparam wide_t  HALF_LSB = wide_t'(64'sd524288);
    localparam wide_t  OUT_MAX  = wide_t'(64'sd2147483647);
    localparam wide_t  OUT_MIN  = wide_t'(-64'sd2147483648);

    typedef struct packed {
        prod_t xx;
        prod_t yy;
        prod_t zz;
        prod_t xy;
        prod_t xz;
        prod_t yz;
        prod_t wx;
        prod_t wy;
        prod_t wz;
    } prods_t;

    typedef struct packed {
        trans_t tx;
        trans_t ty;
        trans_t tz;
    } tvec_t;

    typedef struct packed {
        tvec_t  t;
        scale_t sx;
        scale_t sy;
        scale_t sz;
    } side_t;

    // Per-stage load enables, handed from the top level to the datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // Exact 2*a*b
    function automatic prod_t dbl_mul(input quat_t a, input quat_t b);
        logic signed [2*QUAT_W-1:0] p;
        begin
            p = a * b;
            return prod_t'({p, 1'b0});
        end
    endfunction

endpackage

`default_nettype wire

### rtl/qtrs_products.sv
`timescale 1ns / 1ps
`default_nettype none

module qtrs_products
    import qtrs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire quat_t qx,
    input  wire quat_t qy,
    input  wire quat_t qz,
    input  wire quat_t qw,
    output prods_t     prods_reg
);

    prods_t prods_next;

    always_comb
    begin
        prods_next.xx = dbl_mul(qx, qx);
        prods_next.yy = dbl_mul(qy, qy);
        prods_next.zz = dbl_mul(qz, qz);
        prods_next.xy = dbl_mul(qx, qy);
        prods_next.xz = dbl_mul(qx, qz);
        prods_next.yz = dbl_mul(qy, qz);
        prods_next.wx = dbl_mul(qw, qx);
        prods_next.wy = dbl_mul(qw, qy);
        prods_next.wz = dbl_mul(qw, qz);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prods_reg <= prods_next;
        end
    end

endmodule

`default_nettype wire

### rtl/qtrs_rot.sv
`timescale 1ns / 1ps
`default_nettype none

module qtrs_rot
    import qtrs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire prods_t prods,
    output entry_t      ent_reg [NUM_ENT]
);

    entry_t ent_next [NUM_ENT];
    entry_t xx, yy, zz, xy, xz, yz, wx, wy, wz;

    always_comb
    begin
        xx = entry_t'(prods.xx);
        yy = entry_t'(prods.yy);
        zz = entry_t'(prods.zz);
        xy = entry_t'(prods.xy);
        xz = entry_t'(prods.xz);
        yz = entry_t'(prods.yz);
        wx = entry_t'(prods.wx);
        wy = entry_t'(prods.wy);
        wz = entry_t'(prods.wz);

        ent_next[E00] = ONE_Q28 - yy - zz;
        ent_next[E01] = xy + wz;
        ent_next[E02] = xz - wy;
        ent_next[E10] = xy - wz;
        ent_next[E11] = ONE_Q28 - xx - zz;
        ent_next[E12] = yz + wx;
        ent_next[E20] = xz + wy;
        ent_next[E21] = yz - wx;
        ent_next[E22] = ONE_Q28 - xx - yy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

`default_nettype wire

### rtl/qtrs_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One matrix entry: scale multiply, then round to Q16.16 and clamp.
module qtrs_lane
    import qtrs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en_mul,
    input  wire logic   en_out,
    input  wire entry_t entry,
    input  wire scale_t scale,
    output res_t        res_reg
);

    wide_t mul_reg;
    wide_t mul_next;
    wide_t rnd;
    res_t  res_next;

    assign mul_next = wide_t'(entry) * wide_t'(scale);

    always_comb
    begin
        // round half up, floor shift keeps the sign
        rnd = (mul_reg + HALF_LSB) >>> SHIFT;
        priority if (rnd > OUT_MAX)
        begin
            res_next = res_t'(OUT_MAX);
        end
        else if (rnd < OUT_MIN)
        begin
            res_next = res_t'(OUT_MIN);
        end
        else
        begin
            res_next = rnd[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            mul_reg <= mul_next;
        end
        if (en_out)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### rtl/quaternion_trs_matrix_core.sv
// An input transfer passes through stage registers 1 to 4; out_valid is the stage-4 valid bit.
// Throughput: one transform per cycle while out_stall is low; each of the four stages
// holds independently, so bubbles close up under an output stall.
// Reset (rst_n low, asynchronous) clears the stage valid bits only; the
// datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_trs_matrix_core_assert.svh"

module quaternion_trs_matrix_core
    import qtrs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,

    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire trans_t translation_x,
    input  wire trans_t translation_y,
    input  wire trans_t translation_z,
    input  wire quat_t  quat_x,
    input  wire quat_t  quat_y,
    input  wire quat_t  quat_z,
    input  wire quat_t  quat_w,
    input  wire scale_t scale_x,
    input  wire scale_t scale_y,
    input  wire scale_t scale_z,

    output logic        out_valid,
    input  wire logic   out_stall,
    output res_t        m00,
    output res_t        m01,
    output res_t        m02,
    output res_t        m10,
    output res_t        m11,
    output res_t        m12,
    output res_t        m20,
    output res_t        m21,
    output res_t        m22,
    output res_t        m30,
    output res_t        m31,
    output res_t        m32
);

    // Stage map:
    //   1: nine doubled quaternion products
    //   2: rotation entries (sums against 1.0)
    //   3: entry times row scale, full width
    //   4: round to Q16.16, clamp; this is the output register
    // Translation and scales ride alongside the datapath as side data.

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;
    stage_en_t en;

    side_t  side_in;
    side_t  side1_reg, side2_reg;
    tvec_t  t3_reg, t4_reg;
    prods_t prods;
    entry_t ent [NUM_ENT];
    scale_t row_scale [NUM_ENT];
    res_t   res [NUM_ENT];

    // A stage may take new data when it is empty or its content moves on
    assign ready4 = !v4_reg || !out_stall;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign in_stall = !ready1;

    // Load a stage only when valid data arrives from upstream
    assign en.s1 = ready1 && in_valid;
    assign en.s2 = ready2 && v1_reg;
    assign en.s3 = ready3 && v2_reg;
    assign en.s4 = ready4 && v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign side_in.t.tx = translation_x;
    assign side_in.t.ty = translation_y;
    assign side_in.t.tz = translation_z;
    assign side_in.sx   = scale_x;
    assign side_in.sy   = scale_y;
    assign side_in.sz   = scale_z;

    // Side data: scales are consumed in stage 3, translation goes to the end
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            side1_reg <= side_in;
        end
        if (en.s2)
        begin
            side2_reg <= side1_reg;
        end
        if (en.s3)
        begin
            t3_reg <= side2_reg.t;
        end
        if (en.s4)
        begin
            t4_reg <= t3_reg;
        end
    end

    qtrs_products u_products (
        .clk       (clk),
        .en        (en.s1),
        .qx        (quat_x),
        .qy        (quat_y),
        .qz        (quat_z),
        .qw        (quat_w),
        .prods_reg (prods)
    );

    qtrs_rot u_rot (
        .clk     (clk),
        .en      (en.s2),
        .prods   (prods),
        .ent_reg (ent)
    );

    // Row i of the rotation takes scale component i
    always_comb
    begin
        row_scale[E00] = side2_reg.sx;
        row_scale[E01] = side2_reg.sx;
        row_scale[E02] = side2_reg.sx;
        row_scale[E10] = side2_reg.sy;
        row_scale[E11] = side2_reg.sy;
        row_scale[E12] = side2_reg.sy;
        row_scale[E20] = side2_reg.sz;
        row_scale[E21] = side2_reg.sz;
        row_scale[E22] = side2_reg.sz;
    end

    for (genvar i = 0; i < NUM_ENT; i++)
    begin : g_lane
        qtrs_lane u_lane (
            .clk     (clk),
            .en_mul  (en.s3),
            .en_out  (en.s4),
            .entry   (ent[i]),
            .scale   (row_scale[i]),
            .res_reg (res[i])
        );
    end

    assign out_valid = v4_reg;
    assign m00 = res[E00];
    assign m01 = res[E01];
    assign m02 = res[E02];
    assign m10 = res[E10];
    assign m11 = res[E11];
    assign m12 = res[E12];
    assign m20 = res[E20];
    assign m21 = res[E21];
    assign m22 = res[E22];
    assign m30 = t4_reg.tx;
    assign m31 = t4_reg.ty;
    assign m32 = t4_reg.tz;

    // Input is held off only when every stage is full and the output waits
    `QTRS_ASSERT_SAME(a_stall_full, in_stall, v1_reg && v2_reg && v3_reg && v4_reg && out_stall, "input held off with a free stage")
    // A stage-1 item that may move must show up in stage 2
    `QTRS_ASSERT_NEXT(a_s2_fill, v1_reg && ready2, v2_reg, "item lost between stage 1 and 2")
    // A stage-3 item that may move must reach the output register
    `QTRS_ASSERT_NEXT(a_out_fill, v3_reg && ready4, out_valid, "item lost before output register")

endmodule

`default_nettype wire
